>>> design/sws_pkg.sv
// Shared types and constants of the wire heat and hold sequencer.
`default_nettype none

package sws_pkg;

    localparam int NUM_CH = 3;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_CONTRACT = 3'd1;
    localparam logic [2:0] CMD_RELEASE  = 3'd2;
    localparam logic [2:0] CMD_ACTIVATE = 3'd3;
    localparam logic [2:0] CMD_STOP_ALL = 3'd4;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_HEAT = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;

    localparam logic [1:0] REG_FULL_DUTY = 2'd0;
    localparam logic [1:0] REG_HOLD_DUTY = 2'd1;
    localparam logic [1:0] REG_HEAT_TIME = 2'd2;
    localparam logic [1:0] REG_COOL_TIME = 2'd3;

    localparam logic [7:0]  FULL_DUTY_RST = 8'd255;
    localparam logic [7:0]  HOLD_DUTY_RST = 8'd128;
    localparam logic [15:0] HEAT_TIME_RST = 16'd100;
    localparam logic [15:0] COOL_TIME_RST = 16'd1000;
    localparam logic [15:0] COOL_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  full_duty;
        logic [7:0]  hold_duty;
        logic [15:0] heat_time_ms;
        logic [15:0] cool_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       active;
        logic       ready;
    } chan_status_t;

endpackage

`default_nettype wire

>>> design/sma_wire_heat_hold_sequencer_core.sv
// Top level of the three-channel wire heat and hold sequencer.
//
// A request carries cmd, channel and hold_ms on a valid/ready channel.
// Each accepted request updates the channel state in the same clock edge
// and loads exactly one result (all three duties, the active mask and the
// readiness of the addressed channel) into the result register.
// out_valid rises in the cycle after acceptance; while results are taken,
// one request can be accepted in every cycle (single result register).
// While a result waits and out_ready is low, in_ready is low; in_ready is
// high whenever the result register is empty or being emptied.
// Configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata at any edge with cfg_we high, and must be written only while
// no request is in flight.
// Reset clears every channel to off with its cool timer at zero, loads the
// default configuration and empties the result register.
`default_nettype none

module sma_wire_heat_hold_sequencer_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   cmd,
    input  wire logic [2:0]   channel,
    input  wire logic [15:0]  hold_ms,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        duty_spine,
    output logic [7:0]        duty_front,
    output logic [7:0]        duty_rear,
    output logic [2:0]        active_mask,
    output logic              ready_res
);
    import sws_pkg::*;

    cfg_t         cfg;
    chan_status_t status [NUM_CH];
    logic         req_en;
    logic         ch_valid;
    logic         out_valid_reg;
    logic [7:0]   duty_reg [NUM_CH];
    logic [2:0]   active_reg;
    logic         ready_reg;
    logic [2:0]   active_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign req_en   = in_valid && in_ready;
    assign ch_valid = (channel < 3'(NUM_CH));

    sws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        sws_chan u_chan (
            .clk         (clk),
            .rst_n       (rst_n),
            .req_en      (req_en),
            .cmd         (cmd),
            .sel         (channel == 3'(c)),
            .hold_ms     (hold_ms),
            .cfg         (cfg),
            .status      (status[c])
        );
        assign active_next[c] = status[c].active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_en)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                duty_reg[c] <= status[c].duty;
            end
            active_reg <= active_next;
            ready_reg  <= ch_valid && status[channel[1:0]].ready;
        end
    end

    assign out_valid   = out_valid_reg;
    assign duty_spine  = duty_reg[0];
    assign duty_front  = duty_reg[1];
    assign duty_rear   = duty_reg[2];
    assign active_mask = active_reg;
    assign ready_res   = ready_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        req_en |=> out_valid_reg)
        else $error("Accepted request produced no result.");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req_en && cmd == CMD_STOP_ALL |=> active_reg == 3'd0)
        else $error("Stop-all left a channel active.");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("Input stalled without a waiting result.");

endmodule

`default_nettype wire

>>> design/sws_cfg.sv
// Configuration register file of the sequencer.
`default_nettype none

module sws_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    output sws_pkg::cfg_t     cfg
);
    import sws_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_duty    <= FULL_DUTY_RST;
            cfg_reg.hold_duty    <= HOLD_DUTY_RST;
            cfg_reg.heat_time_ms <= HEAT_TIME_RST;
            cfg_reg.cool_time_ms <= COOL_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FULL_DUTY: cfg_reg.full_duty    <= cfg_wdata[7:0];
                REG_HOLD_DUTY: cfg_reg.hold_duty    <= cfg_wdata[7:0];
                REG_HEAT_TIME: cfg_reg.heat_time_ms <= cfg_wdata;
                REG_COOL_TIME: cfg_reg.cool_time_ms <= cfg_wdata;
                default:       cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/sws_chan.sv
// State and timers of one wire channel.
`default_nettype none

module sws_chan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_en,
    input  wire logic [2:0]     cmd,
    input  wire logic           sel,
    input  wire logic [15:0]    hold_ms,
    input  sws_pkg::cfg_t       cfg,
    output sws_pkg::chan_status_t status
);
    import sws_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] heat_left_reg, heat_left_next;
    logic        pending_reg, pending_next;
    logic [15:0] hold_left_reg, hold_left_next;
    logic [15:0] cool_reg, cool_next;
    logic [15:0] heat_dec;
    logic [15:0] hold_dec;

    assign heat_dec = (heat_left_reg != 16'd0) ? heat_left_reg - 16'd1 : 16'd0;
    assign hold_dec = (hold_left_reg != 16'd0) ? hold_left_reg - 16'd1 : 16'd0;

    always_comb
    begin
        mode_next      = mode_reg;
        heat_left_next = heat_left_reg;
        pending_next   = pending_reg;
        hold_left_next = hold_left_reg;
        cool_next      = cool_reg;
        if (req_en)
        begin
            unique case (cmd) inside
                CMD_TICK:
                begin
                    if (cool_reg != COOL_MAX)
                    begin
                        cool_next = cool_reg + 16'd1;
                    end
                    if (mode_reg == MODE_HEAT)
                    begin
                        heat_left_next = heat_dec;
                        if (heat_dec == 16'd0)
                        begin
                            mode_next = MODE_HOLD;
                            if (pending_reg && hold_left_reg == 16'd0)
                            begin
                                mode_next      = MODE_OFF;
                                pending_next   = 1'b0;
                                hold_left_next = 16'd0;
                                cool_next      = 16'd0;
                            end
                        end
                    end
                    else if (mode_reg == MODE_HOLD && pending_reg)
                    begin
                        hold_left_next = hold_dec;
                        if (hold_dec == 16'd0)
                        begin
                            mode_next      = MODE_OFF;
                            pending_next   = 1'b0;
                            heat_left_next = 16'd0;
                            cool_next      = 16'd0;
                        end
                    end
                end
                CMD_CONTRACT, CMD_ACTIVATE:
                begin
                    if (sel)
                    begin
                        pending_next   = (cmd == CMD_ACTIVATE);
                        hold_left_next = (cmd == CMD_ACTIVATE) ? hold_ms : 16'd0;
                        mode_next      = MODE_HEAT;
                        heat_left_next = cfg.heat_time_ms;
                        if (cfg.heat_time_ms == 16'd0)
                        begin
                            mode_next = MODE_HOLD;
                            if (cmd == CMD_ACTIVATE && hold_ms == 16'd0)
                            begin
                                mode_next    = MODE_OFF;
                                pending_next = 1'b0;
                                cool_next    = 16'd0;
                            end
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (sel)
                    begin
                        mode_next      = MODE_OFF;
                        pending_next   = 1'b0;
                        hold_left_next = 16'd0;
                        heat_left_next = 16'd0;
                        cool_next      = 16'd0;
                    end
                end
                CMD_STOP_ALL:
                begin
                    mode_next      = MODE_OFF;
                    pending_next   = 1'b0;
                    hold_left_next = 16'd0;
                    heat_left_next = 16'd0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            heat_left_reg <= 16'd0;
            pending_reg   <= 1'b0;
            hold_left_reg <= 16'd0;
            cool_reg      <= 16'd0;
        end
        else
        begin
            mode_reg      <= mode_next;
            heat_left_reg <= heat_left_next;
            pending_reg   <= pending_next;
            hold_left_reg <= hold_left_next;
            cool_reg      <= cool_next;
        end
    end

    always_comb
    begin
        status.duty   = (mode_next == MODE_HEAT) ? cfg.full_duty
                      : (mode_next == MODE_HOLD) ? cfg.hold_duty : 8'd0;
        status.active = (mode_next != MODE_OFF);
        status.ready  = (mode_next == MODE_OFF) && (cool_next >= cfg.cool_time_ms);
    end

    a_off_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_OFF |-> heat_left_reg == 16'd0 && hold_left_reg == 16'd0
                                 && !pending_reg)
        else $error("Off channel holds live timer state.");

    a_heat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HEAT |-> heat_left_reg != 16'd0)
        else $error("Heating channel has no heat time left.");

    a_hold_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> hold_left_reg == 16'd0)
        else $error("Hold counter set without a pending release.");

endmodule

`default_nettype wire
